// ===== rtl/tsst_pkg.sv =====
`timescale 1ns / 1ps

package tsst_pkg;

  // Width of the index fields on the ports.
  localparam int IDX_W = 10;
  // Internal index width: signed, so that low+1 past the end and high-1 below
  // zero stay representable.
  localparam int SIDX_W = IDX_W + 2;

  // Division of a span (below 1024) by three as a multiply and shift.
  localparam int THIRD_MUL   = 683;
  localparam int THIRD_SHIFT = 11;

  // Microprogram step addresses.
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] ST_SPAN  = 4'd1;
  localparam logic [PC_W-1:0] ST_MID   = 4'd2;
  localparam logic [PC_W-1:0] ST_TST_L = 4'd3;
  localparam logic [PC_W-1:0] ST_TST_H = 4'd4;
  localparam logic [PC_W-1:0] ST_SM_L  = 4'd5;
  localparam logic [PC_W-1:0] ST_SM_H  = 4'd6;
  localparam logic [PC_W-1:0] ST_SM_M  = 4'd7;
  localparam logic [PC_W-1:0] ST_DONE  = 4'd8;

  // Table read address select.
  typedef enum logic [2:0] {
    RD_NONE,
    RD_LOW,
    RD_HIGH,
    RD_LOWP1,
    RD_MIDL,
    RD_MIDH
  } rd_sel_t;

  // Branch conditions.
  typedef enum logic [3:0] {
    C_NONE,
    C_START,
    C_DNEG,
    C_DSMALL,
    C_D2,
    C_EQ,
    C_LT,
    C_GT,
    C_HOLD
  } cond_t;

  // Datapath actions.
  typedef enum logic [3:0] {
    A_NONE,
    A_LOAD,
    A_THIRD,
    A_MIDS,
    A_HIGH_ML,
    A_LOW_MH,
    A_MIDDLE,
    A_HIT_LOW,
    A_HIT_HIGH,
    A_HIT_LOWP1,
    A_HIT_MIDL,
    A_HIT_MIDH,
    A_MISS,
    A_EMIT
  } act_t;

  // One control word: two prioritized branches and a fall-through.
  typedef struct packed {
    logic            take;
    rd_sel_t         rd_sel;
    cond_t           c1;
    act_t            a1;
    logic [PC_W-1:0] t1;
    cond_t           c2;
    act_t            a2;
    logic [PC_W-1:0] t2;
    act_t            a0;
    logic [PC_W-1:0] t0;
  } ctl_t;

  // Control store.
  function automatic ctl_t ctl_rom(input logic [PC_W-1:0] pc);
    ctl_t w;
    w = '{take: 1'b0, rd_sel: RD_NONE, c1: C_NONE, a1: A_NONE, t1: ST_IDLE,
          c2: C_NONE, a2: A_NONE, t2: ST_IDLE, a0: A_NONE, t0: ST_IDLE};
    unique case (pc)
      ST_IDLE: begin
        w.take = 1'b1;
        w.c1 = C_START;  w.a1 = A_LOAD;   w.t1 = ST_SPAN;
        w.t0 = ST_IDLE;
      end
      ST_SPAN: begin
        w.rd_sel = RD_LOW;
        w.c1 = C_DNEG;   w.a1 = A_MISS;   w.t1 = ST_DONE;
        w.c2 = C_DSMALL; w.t2 = ST_SM_L;
        w.a0 = A_THIRD;  w.t0 = ST_MID;
      end
      ST_MID: begin
        w.rd_sel = RD_MIDL;
        w.a0 = A_MIDS;   w.t0 = ST_TST_L;
      end
      ST_TST_L: begin
        w.rd_sel = RD_MIDH;
        w.c1 = C_EQ;     w.a1 = A_HIT_MIDL; w.t1 = ST_DONE;
        w.c2 = C_LT;     w.a2 = A_HIGH_ML;  w.t2 = ST_SPAN;
        w.t0 = ST_TST_H;
      end
      ST_TST_H: begin
        w.c1 = C_EQ;     w.a1 = A_HIT_MIDH; w.t1 = ST_DONE;
        w.c2 = C_GT;     w.a2 = A_LOW_MH;   w.t2 = ST_SPAN;
        w.a0 = A_MIDDLE; w.t0 = ST_SPAN;
      end
      ST_SM_L: begin
        w.rd_sel = RD_HIGH;
        w.c1 = C_EQ;     w.a1 = A_HIT_LOW;  w.t1 = ST_DONE;
        w.t0 = ST_SM_H;
      end
      ST_SM_H: begin
        w.rd_sel = RD_LOWP1;
        w.c1 = C_EQ;     w.a1 = A_HIT_HIGH; w.t1 = ST_DONE;
        w.c2 = C_D2;     w.t2 = ST_SM_M;
        w.a0 = A_MISS;   w.t0 = ST_DONE;
      end
      ST_SM_M: begin
        w.c1 = C_EQ;     w.a1 = A_HIT_LOWP1; w.t1 = ST_DONE;
        w.a0 = A_MISS;   w.t0 = ST_DONE;
      end
      ST_DONE: begin
        w.c1 = C_HOLD;   w.t1 = ST_DONE;
        w.a0 = A_EMIT;   w.t0 = ST_IDLE;
      end
      default: begin
        w.t0 = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/ternary_search_sorted_table_top.sv =====
// Ternary search over a table of signed values held in a memory with one write
// port and one registered read port. A word with in_mode 0 writes
// in_entry_value to in_entry_index (ignored past the end of the table),
// gives no result and leaves the block ready for the next word. A word with
// in_mode 1 searches the inclusive range [in_search_low, in_search_high] for
// in_search_key, with the upper bound clamped to the last entry, and returns
// one result word: out_found and out_position (0 when not found). The search
// is run by a small microprogram that reads the memory at most once per step.
// A narrowing pass computes the span and its third, reads the lower middle,
// then compares the key with the lower and, if needed, the upper middle; the
// final span of up to three entries is compared entry by entry. The table must
// be written before it is searched; values and keys are compared on their low
// VALUE_WIDTH bits, sign-extended.
`timescale 1ns / 1ps

module ternary_search_sorted_table_top
  import tsst_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_mode,
  input  logic [IDX_W-1:0]         in_entry_index,
  input  logic signed [31:0]       in_entry_value,
  input  logic signed [31:0]       in_search_key,
  input  logic [IDX_W-1:0]         in_search_low,
  input  logic [IDX_W-1:0]         in_search_high,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_found,
  output logic [IDX_W-1:0]         out_position
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic signed [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];

  logic [PC_W-1:0]               pc_r, pc_nxt;
  logic signed [SIDX_W-1:0]      low_r, high_r, midl_r, midh_r;
  logic [IDX_W-1:0]              third_r;
  logic signed [VALUE_WIDTH-1:0] key_r, rd_data_r;
  logic                          fnd_r;
  logic [IDX_W-1:0]              pos_r;
  logic                          out_valid_r, out_found_r;
  logic [IDX_W-1:0]              out_position_r;

  ctl_t                          cw;
  act_t                          act;
  logic                          take_word;
  logic signed [SIDX_W-1:0]      span, midl_c, midh_c, rd_idx, hi_clamp;
  logic [2*IDX_W-1:0]            prod;
  logic signed [63:0]            val_ext, key_ext;

  // Current control word.
  assign cw        = ctl_rom(pc_r);
  assign in_ready  = cw.take;
  assign take_word = in_valid && cw.take;

  // Span, third and the two split points.
  assign span   = high_r - low_r;
  assign prod   = span[IDX_W-1:0] * IDX_W'(THIRD_MUL);
  assign midl_c = low_r + $signed({2'b00, third_r});
  assign midh_c = low_r + $signed({1'b0, third_r, 1'b0});

  // Inputs sign-extended, then cut to the stored width.
  assign val_ext = 64'(in_entry_value);
  assign key_ext = 64'(in_search_key);

  // Upper bound clamp to the last entry.
  assign hi_clamp = (32'(in_search_high) > TABLE_DEPTH - 1) ?
                    SIDX_W'(TABLE_DEPTH - 1) : SIDX_W'(in_search_high);

  // Condition evaluation.
  function automatic logic cond_hit(input cond_t c);
    logic r;
    unique case (c)
      C_NONE:   r = 1'b0;
      C_START:  r = in_valid && in_mode;
      C_DNEG:   r = span < 0;
      C_DSMALL: r = span < 3;
      C_D2:     r = span == 2;
      C_EQ:     r = key_r == rd_data_r;
      C_LT:     r = key_r < rd_data_r;
      C_GT:     r = key_r > rd_data_r;
      C_HOLD:   r = out_valid_r && !out_ready;
      default:  r = 1'b0;
    endcase
    return r;
  endfunction

  // Sequencer: next step and the action that goes with the chosen branch.
  always_comb begin
    priority if (cond_hit(cw.c1)) begin
      pc_nxt = cw.t1;
      act    = cw.a1;
    end else if (cond_hit(cw.c2)) begin
      pc_nxt = cw.t2;
      act    = cw.a2;
    end else begin
      pc_nxt = cw.t0;
      act    = cw.a0;
    end
  end

  // Read address select.
  always_comb begin
    unique case (cw.rd_sel)
      RD_LOW:   rd_idx = low_r;
      RD_HIGH:  rd_idx = high_r;
      RD_LOWP1: rd_idx = low_r + SIDX_W'(1);
      RD_MIDL:  rd_idx = midl_c;
      RD_MIDH:  rd_idx = midh_r;
      default:  rd_idx = low_r;
    endcase
  end

  // Table memory: one write port for load words, one registered read port.
  always_ff @(posedge clk) begin
    if (take_word && !in_mode && (32'(in_entry_index) < TABLE_DEPTH)) begin
      mem[AW'(in_entry_index)] <= val_ext[VALUE_WIDTH-1:0];
    end
    if (cw.rd_sel != RD_NONE) begin
      rd_data_r <= mem[AW'(unsigned'(rd_idx))];
    end
  end

  // Step counter and result handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (act == A_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers driven by the action of the step.
  always_ff @(posedge clk) begin
    unique case (act)
      A_NONE: begin
      end
      A_LOAD: begin
        low_r  <= SIDX_W'(in_search_low);
        high_r <= hi_clamp;
        key_r  <= key_ext[VALUE_WIDTH-1:0];
      end
      A_THIRD:  third_r <= IDX_W'(prod >> THIRD_SHIFT);
      A_MIDS: begin
        midl_r <= midl_c;
        midh_r <= midh_c;
      end
      A_HIGH_ML: high_r <= midl_r - SIDX_W'(1);
      A_LOW_MH:  low_r  <= midh_r + SIDX_W'(1);
      A_MIDDLE: begin
        low_r  <= midl_r + SIDX_W'(1);
        high_r <= midh_r - SIDX_W'(1);
      end
      A_HIT_LOW: begin
        fnd_r <= 1'b1;
        pos_r <= low_r[IDX_W-1:0];
      end
      A_HIT_HIGH: begin
        fnd_r <= 1'b1;
        pos_r <= high_r[IDX_W-1:0];
      end
      A_HIT_LOWP1: begin
        fnd_r <= 1'b1;
        pos_r <= low_r[IDX_W-1:0] + IDX_W'(1);
      end
      A_HIT_MIDL: begin
        fnd_r <= 1'b1;
        pos_r <= midl_r[IDX_W-1:0];
      end
      A_HIT_MIDH: begin
        fnd_r <= 1'b1;
        pos_r <= midh_r[IDX_W-1:0];
      end
      A_MISS: begin
        fnd_r <= 1'b0;
        pos_r <= '0;
      end
      A_EMIT: begin
        out_found_r    <= fnd_r;
        out_position_r <= pos_r;
      end
      default: begin
      end
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;

endmodule

// ===== rtl/tsst_checker.sv =====
`timescale 1ns / 1ps

module tsst_checker
  import tsst_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_mode,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_found,
  input logic [IDX_W-1:0] out_position
);

  // A search word occupies the block, so input is refused on the next cycle.
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_mode) |=> !in_ready)
    else $error("input taken right after a search word");

  // A load word leaves the block ready for the next word.
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_mode) |=> in_ready)
    else $error("block busy after a load word");

  // A new result appears only once the search has finished.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while a search is still running");

  // A miss always reports position zero.
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_position == '0))
    else $error("miss with nonzero position");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_found) && $stable(out_position)))
    else $error("stalled result word changed");

endmodule

bind ternary_search_sorted_table_top tsst_checker u_tsst_checker (.*);
